### hw/rtl/seird_pkg.sv
// Shared types, constants and helpers for the SEIRD Heun step integrator.
// Used by seird_mdu and seird_heun_step; depends on nothing else.
`timescale 1ns / 1ps

package seird_pkg;

  localparam int unsigned FRAC_BITS_DEF = 24;
  localparam int unsigned VAL_W  = 48;   // compartment width, unsigned Q24.24
  localparam int unsigned RATE_W = 25;   // rate register width, Q1.24
  localparam int unsigned TOT_W  = 51;   // sum of five compartments
  localparam int unsigned ACC_W  = 62;   // signed working value, clamped to +-2^60
  localparam int unsigned MAG_W  = 61;   // magnitude of a working value
  localparam int unsigned NREG   = 8;
  localparam int unsigned IDX_W  = 3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_AE    = 3'd0;
  localparam logic [IDX_W-1:0] REG_AI    = 3'd1;
  localparam logic [IDX_W-1:0] REG_KAPPA = 3'd2;
  localparam logic [IDX_W-1:0] REG_RHO   = 3'd3;
  localparam logic [IDX_W-1:0] REG_BETA  = 3'd4;
  localparam logic [IDX_W-1:0] REG_MU    = 3'd5;
  localparam logic [IDX_W-1:0] REG_GAMMA = 3'd6;
  localparam logic [IDX_W-1:0] REG_H     = 3'd7;

  localparam logic [RATE_W-1:0] REG_RESET [NREG] = '{
    25'd16760439, 25'd16760439, 25'd704643, 25'd15971910,
    25'd16760439, 25'd315412, 25'd0, 25'd167772
  };

  // request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  localparam logic [MAG_W-1:0]  LIM_MAG = {1'b1, 60'b0};
  localparam logic signed [63:0] LIM64  = 64'sh1000_0000_0000_0000;

  typedef enum logic [1:0] {
    MODE_SHR  = 2'd0,   // product >> FRAC_BITS
    MODE_SHR1 = 2'd1,   // product >> (FRAC_BITS + 1)
    MODE_DIV  = 2'd2    // product / divisor
  } mdu_mode_e;

  typedef struct packed {
    logic                    start;
    mdu_mode_e               mode;
    logic signed [ACC_W-1:0] a;
    logic signed [ACC_W-1:0] b;
    logic [TOT_W-1:0]        div;
  } mdu_req_t;

  // clamp a wide signed sum to +-2^60
  function automatic logic signed [ACC_W-1:0] sat62(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v > LIM64) begin
      r = LIM64;
    end else if (v < -LIM64) begin
      r = -LIM64;
    end else begin
      r = v;
    end
    return r[ACC_W-1:0];
  endfunction

endpackage

### hw/rtl/seird_mdu.sv
// Shared multiply / scale / divide unit: a*b >> F, a*b >> (F+1) or a*b / d,
// magnitude truncated and clamped to +-2^60. Depends on seird_pkg.
`timescale 1ns / 1ps

module seird_mdu #(
  parameter int unsigned FRAC_BITS = seird_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  seird_pkg::mdu_req_t                 req_i,
  output logic                                done_o,
  output logic signed [seird_pkg::ACC_W-1:0]  res_o
);

  localparam int unsigned PW = 2 * seird_pkg::MAG_W;  // 122-bit product
  localparam int unsigned HW = 31;                     // partial operand width
  localparam int unsigned TW = seird_pkg::TOT_W;
  localparam int unsigned MW = seird_pkg::MAG_W;

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_MUL  = 3'd1;
  localparam logic [2:0] U_POST = 3'd2;
  localparam logic [2:0] U_DIV  = 3'd3;
  localparam logic [2:0] U_FIN  = 3'd4;

  logic [2:0]            st_q, st_d;
  logic [5:0]            cnt_q, cnt_d;
  logic                  done_q;
  logic [MW-1:0]         ma_q, mb_q, quo_q;
  logic                  neg_q;
  seird_pkg::mdu_mode_e  mode_q;
  logic [TW-1:0]         div_q;
  logic [PW-1:0]         prod_q;
  logic [TW-1:0]         rem_q;
  logic signed [seird_pkg::ACC_W-1:0] res_q;

  logic [HW-1:0]   ah, bh;
  logic [2*HW-1:0] pp;
  logic [6:0]      sh_amt;
  logic [PW-1:0]   shifted;
  logic [TW:0]     rs;
  logic            rs_ge;
  logic [MW-1:0]   qc;

  always_comb begin
    ah     = cnt_q[1] ? {1'b0, ma_q[MW-1:HW]} : ma_q[HW-1:0];
    bh     = cnt_q[0] ? {1'b0, mb_q[MW-1:HW]} : mb_q[HW-1:0];
    pp     = (2*HW)'(ah) * (2*HW)'(bh);
    sh_amt = (cnt_q[1] ? 7'd31 : 7'd0) + (cnt_q[0] ? 7'd31 : 7'd0);
    shifted = (mode_q == seird_pkg::MODE_SHR1) ? (prod_q >> (FRAC_BITS + 1))
                                               : (prod_q >> FRAC_BITS);
    rs     = {rem_q, prod_q[MW-1]};
    rs_ge  = rs >= {1'b0, div_q};
    qc     = (quo_q > seird_pkg::LIM_MAG) ? seird_pkg::LIM_MAG : quo_q;
  end

  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    unique case (st_q)
      U_IDLE: begin
        if (req_i.start) begin
          st_d  = U_MUL;
          cnt_d = '0;
        end
      end
      U_MUL: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd3) st_d = U_POST;
      end
      U_POST: begin
        cnt_d = '0;
        if (mode_q == seird_pkg::MODE_DIV && div_q != '0 &&
            prod_q[PW-1:MW] < PW'(div_q) >> 0) begin
          st_d = U_DIV;
        end else begin
          st_d = U_FIN;
        end
      end
      U_DIV: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(MW - 1)) st_d = U_FIN;
      end
      U_FIN:   st_d = U_IDLE;
      default: st_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= U_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      done_q <= (st_q == U_FIN);
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      U_IDLE: begin
        if (req_i.start) begin
          ma_q   <= req_i.a[seird_pkg::ACC_W-1] ? MW'(-req_i.a) : MW'(req_i.a);
          mb_q   <= req_i.b[seird_pkg::ACC_W-1] ? MW'(-req_i.b) : MW'(req_i.b);
          neg_q  <= req_i.a[seird_pkg::ACC_W-1] ^ req_i.b[seird_pkg::ACC_W-1];
          mode_q <= req_i.mode;
          div_q  <= req_i.div;
          prod_q <= '0;
        end
      end
      U_MUL: begin
        prod_q <= prod_q + (PW'(pp) << sh_amt);
      end
      U_POST: begin
        rem_q <= prod_q[MW+TW-1:MW];
        if (mode_q == seird_pkg::MODE_DIV) begin
          // quotient too large settles here; divide by zero gives zero
          if (div_q != '0 && prod_q[PW-1:MW] >= MW'(div_q)) begin
            quo_q <= seird_pkg::LIM_MAG;
          end else begin
            quo_q <= '0;
          end
        end else begin
          quo_q <= (shifted > PW'(seird_pkg::LIM_MAG)) ? seird_pkg::LIM_MAG
                                                       : shifted[MW-1:0];
        end
      end
      U_DIV: begin
        rem_q  <= rs_ge ? TW'(rs - {1'b0, div_q}) : rs[TW-1:0];
        quo_q  <= {quo_q[MW-2:0], rs_ge};
        prod_q <= prod_q << 1;
      end
      U_FIN: begin
        res_q <= neg_q ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### hw/rtl/seird_heun_step.sv
// SEIRD Heun step integrator top level. A load request takes the five compartments
// and returns them with the step count reset; a step request runs through the one
// shared multiply/divide unit (8 scaled products and one divide per derivative, two
// derivatives with five predictor products between them, then five final scaled
// products); a zero total or a clamped quotient skips the divide loop. One request
// is in work at a time; the next is taken once the result sits in the output
// register. Async active-low reset clears the compartments, step count and control,
// and sets the rate registers to their defaults.
// Depends on seird_pkg and seird_mdu.
`timescale 1ns / 1ps

module seird_heun_step #(
  parameter int unsigned FRAC_BITS = seird_pkg::FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // init_susceptible, init_exposed, init_infected, init_recovered, init_dead
  input  logic [239:0] s_axis_tdata,
  // req_type
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // step_index, susceptible_out, exposed_out, infected_out, recovered_out, dead_out
  output logic [271:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [seird_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [seird_pkg::RATE_W-1:0] cfg_data_i
);

  localparam int unsigned AW = seird_pkg::ACC_W;
  localparam int unsigned VW = seird_pkg::VAL_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_COMB  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [1:0] PH_EVAL = 2'd0;
  localparam logic [1:0] PH_PRED = 2'd1;
  localparam logic [1:0] PH_FIN  = 2'd2;

  // derivative term slots
  localparam logic [3:0] T_AI   = 4'd0;
  localparam logic [3:0] T_AE   = 4'd1;
  localparam logic [3:0] T_INF  = 4'd2;
  localparam logic [3:0] T_LOSS = 4'd3;
  localparam logic [3:0] T_INC  = 4'd4;
  localparam logic [3:0] T_EREC = 4'd5;
  localparam logic [3:0] T_IREC = 4'd6;
  localparam logic [3:0] T_DIE  = 4'd7;
  localparam logic [3:0] T_EKR  = 4'd8;

  logic [2:0]  st_q;
  logic [1:0]  ph_q;
  logic [3:0]  idx_q;
  logic        pass_q;
  logic        m_valid_q;
  logic [271:0] m_data_q;

  logic [seird_pkg::RATE_W-1:0] cfg_q [seird_pkg::NREG];
  logic [VW-1:0]          comp_q [5];
  logic [31:0]            step_q;
  logic [seird_pkg::TOT_W-1:0] tot_q;
  logic signed [AW-1:0]   x1_q [5];
  logic signed [AW-1:0]   d0_q [5];
  logic signed [AW-1:0]   d1_q [5];
  logic signed [AW-1:0]   term_q [9];

  logic signed [AW-1:0]   x0s [5];
  logic signed [AW-1:0]   pt [5];
  logic signed [AW-1:0]   dn [5];
  logic signed [AW-1:0]   force_v;
  logic signed [63:0]     nv;
  logic [2:0]             k;
  seird_pkg::mdu_req_t    req;
  logic                   u_done;
  logic signed [AW-1:0]   u_res;
  logic                   in_acc;

  function automatic logic signed [AW-1:0] rate(input logic [25:0] r);
    return $signed({36'b0, r});
  endfunction

  assign k      = idx_q[2:0];
  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      x0s[i] = $signed({14'b0, comp_q[i]});
      pt[i]  = pass_q ? x1_q[i] : x0s[i];
    end
    force_v = seird_pkg::sat62(64'(term_q[T_AI]) + 64'(term_q[T_AE]));
    // derivative from the stored terms
    dn[0] = seird_pkg::sat62(64'(term_q[T_LOSS]) - 64'(term_q[T_INF]));
    dn[1] = seird_pkg::sat62(64'(term_q[T_INF]) - 64'(term_q[T_EKR]));
    dn[2] = seird_pkg::sat62(64'(term_q[T_INC]) - 64'(term_q[T_IREC])
                             - 64'(term_q[T_DIE]));
    dn[3] = seird_pkg::sat62(64'(term_q[T_IREC]) + 64'(term_q[T_EREC])
                             - 64'(term_q[T_LOSS]));
    dn[4] = term_q[T_DIE];
    nv    = 64'(x0s[k]) + 64'(u_res);
  end

  // operand selection for the shared unit
  always_comb begin
    req.start = (st_q == S_ISSUE);
    req.mode  = seird_pkg::MODE_SHR;
    req.a     = '0;
    req.b     = '0;
    req.div   = tot_q;
    unique case (ph_q)
      PH_EVAL: begin
        case (idx_q)
          T_AI:   begin req.a = pt[2]; req.b = rate(26'(cfg_q[seird_pkg::REG_AI])); end
          T_AE:   begin req.a = pt[1]; req.b = rate(26'(cfg_q[seird_pkg::REG_AE])); end
          T_INF:  begin
            req.a    = pt[0];
            req.b    = force_v;
            req.mode = seird_pkg::MODE_DIV;
          end
          T_LOSS: begin req.a = pt[3]; req.b = rate(26'(cfg_q[seird_pkg::REG_GAMMA])); end
          T_INC:  begin req.a = pt[1]; req.b = rate(26'(cfg_q[seird_pkg::REG_KAPPA])); end
          T_EREC: begin req.a = pt[1]; req.b = rate(26'(cfg_q[seird_pkg::REG_RHO])); end
          T_IREC: begin req.a = pt[2]; req.b = rate(26'(cfg_q[seird_pkg::REG_BETA])); end
          T_DIE:  begin req.a = pt[2]; req.b = rate(26'(cfg_q[seird_pkg::REG_MU])); end
          default: begin
            req.a = pt[1];
            req.b = rate(26'(cfg_q[seird_pkg::REG_KAPPA]) + 26'(cfg_q[seird_pkg::REG_RHO]));
          end
        endcase
      end
      PH_PRED: begin
        req.a = d0_q[k];
        req.b = rate(26'(cfg_q[seird_pkg::REG_H]));
      end
      PH_FIN: begin
        req.a    = seird_pkg::sat62(64'(d0_q[k]) + 64'(d1_q[k]));
        req.b    = rate(26'(cfg_q[seird_pkg::REG_H]));
        req.mode = seird_pkg::MODE_SHR1;
      end
      default: ;
    endcase
  end

  seird_mdu #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .done_o (u_done),
    .res_o  (u_res)
  );

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      ph_q      <= PH_EVAL;
      idx_q     <= '0;
      pass_q    <= 1'b0;
      m_valid_q <= 1'b0;
      step_q    <= '0;
      for (int i = 0; i < 5; i++) comp_q[i] <= '0;
      for (int i = 0; i < seird_pkg::NREG; i++) cfg_q[i] <= seird_pkg::REG_RESET[i];
    end else begin
      if (cfg_we_i) cfg_q[cfg_idx_i] <= cfg_data_i;
      // load the output register when a result is ready, drop it once taken
      if (st_q == S_DONE && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (st_q)
        S_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser == seird_pkg::REQ_LOAD) begin
              // load: take the five compartments, restart the count
              for (int i = 0; i < 5; i++) comp_q[i] <= s_axis_tdata[i*VW +: VW];
              step_q <= '0;
              st_q   <= S_DONE;
            end else begin
              ph_q   <= PH_EVAL;
              idx_q  <= '0;
              pass_q <= 1'b0;
              st_q   <= S_ISSUE;
            end
          end
        end
        S_ISSUE: st_q <= S_WAIT;
        S_WAIT: begin
          if (u_done) begin
            unique case (ph_q)
              PH_EVAL: begin
                if (idx_q == T_EKR) begin
                  st_q <= S_COMB;
                end else begin
                  idx_q <= idx_q + 4'd1;
                  st_q  <= S_ISSUE;
                end
              end
              PH_PRED: begin
                if (k == 3'd4) begin
                  ph_q   <= PH_EVAL;
                  pass_q <= 1'b1;
                  idx_q  <= '0;
                end else begin
                  idx_q <= idx_q + 4'd1;
                end
                st_q <= S_ISSUE;
              end
              default: begin
                // final update: clamp to 0..max
                if (nv < 0) begin
                  comp_q[k] <= '0;
                end else if (nv > 64'sh0000_FFFF_FFFF_FFFF) begin
                  comp_q[k] <= '1;
                end else begin
                  comp_q[k] <= nv[VW-1:0];
                end
                if (k == 3'd4) begin
                  step_q <= step_q + 32'd1;
                  st_q   <= S_DONE;
                end else begin
                  idx_q <= idx_q + 4'd1;
                  st_q  <= S_ISSUE;
                end
              end
            endcase
          end
        end
        S_COMB: begin
          idx_q <= '0;
          ph_q  <= pass_q ? PH_FIN : PH_PRED;
          st_q  <= S_ISSUE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!m_valid_q || m_axis_tready) begin
            st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // working values
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tot_q <= seird_pkg::TOT_W'(comp_q[0]) + seird_pkg::TOT_W'(comp_q[1])
             + seird_pkg::TOT_W'(comp_q[2]) + seird_pkg::TOT_W'(comp_q[3])
             + seird_pkg::TOT_W'(comp_q[4]);
    end
    if (st_q == S_WAIT && u_done) begin
      if (ph_q == PH_EVAL) term_q[idx_q] <= u_res;
      if (ph_q == PH_PRED) x1_q[k] <= seird_pkg::sat62(64'(x0s[k]) + 64'(u_res));
    end
    if (st_q == S_COMB) begin
      for (int i = 0; i < 5; i++) begin
        if (pass_q) d1_q[i] <= dn[i];
        else        d0_q[i] <= dn[i];
      end
    end
    if (st_q == S_DONE && (!m_valid_q || m_axis_tready)) begin
      m_data_q <= {comp_q[4], comp_q[3], comp_q[2], comp_q[1], comp_q[0], step_q};
    end
  end

  assign s_axis_tready = (st_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef SYNTHESIS
  // unit only finishes while the sequencer waits on it
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_done |-> (st_q == S_WAIT))
    else $error("unit result outside wait state");

  // a finished result holds back while the output register is full
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DONE && m_valid_q && !m_axis_tready) |=> (st_q == S_DONE))
    else $error("result dropped while output stalled");

  // predictor and final passes walk five compartments only
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_ISSUE && ph_q != PH_EVAL) |-> (idx_q <= 4'd4))
    else $error("compartment index out of range");
`endif

endmodule

### tb/sv/tb_seird_heun_step.sv
// Testbench for seird_heun_step: SEIRD compartments advanced by Heun steps.
// Drives load and step requests, predicts every result in fixed point and checks it.
// Depends on seird_pkg and the seird_heun_step RTL.
`timescale 1ns / 1ps

module tb_seird_heun_step;

  typedef logic signed [63:0] s64_t;
  typedef s64_t comp5_t [5];

  localparam s64_t SAT_LIM  = 64'sh1000_0000_0000_0000;
  localparam logic [63:0] Q_ONE = 64'd1 << seird_pkg::FRAC_BITS_DEF;
  localparam logic [47:0] VAL_MAX = {seird_pkg::VAL_W{1'b1}};
  localparam logic [seird_pkg::RATE_W-1:0] RATE_ONE = 25'd16777216;

  typedef struct packed {
    logic [31:0] steps;
    logic [47:0] sus;
    logic [47:0] exp_c;
    logic [47:0] inf;
    logic [47:0] rec;
    logic [47:0] dead;
  } seird_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [239:0] s_axis_tdata = '0;  // init_susceptible, init_exposed, init_infected,
                                    // init_recovered, init_dead
  logic s_axis_tuser = seird_pkg::REQ_LOAD;    // req_type
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [271:0] m_axis_tdata;       // step_index, susceptible_out, exposed_out,
                                    // infected_out, recovered_out, dead_out
  logic cfg_we_i = 1'b0;
  logic [seird_pkg::IDX_W-1:0] cfg_idx_i = seird_pkg::REG_AE;
  logic [seird_pkg::RATE_W-1:0] cfg_data_i = '0;

  seird_heun_step DUT (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predictor state: its own copy of the rates, compartments and step count.
  logic [seird_pkg::RATE_W-1:0] rate_q [seird_pkg::NREG];
  logic [47:0] pop_q [5];
  logic [31:0] step_cnt_q;

  seird_result_t pending_results [$];
  int err_count = 0;
  bit no_idle = 1'b0;      // set for stretches without gaps on either side
  int hold_request = 0;    // long receiver hold, picked up by the receiver process

  // Clamp a working value to +-2^60.
  function automatic s64_t clamp60(s64_t v);
    if (v > SAT_LIM) return SAT_LIM;
    if (v < -SAT_LIM) return -SAT_LIM;
    return v;
  endfunction

  // a*b/d at full width, magnitude truncated, clamped to 2^60; zero when d is zero.
  function automatic s64_t mul_div(s64_t a, s64_t b, logic [63:0] d);
    logic neg;
    logic [127:0] ma, mb, prod, quo;
    if (d == 0) return 0;
    neg = (a < 0) != (b < 0);
    ma = {64'd0, (a < 0) ? -a : a};
    mb = {64'd0, (b < 0) ? -b : b};
    prod = ma * mb;
    quo = prod / {64'd0, d};
    if (quo > 128'(SAT_LIM)) quo = 128'(SAT_LIM);
    return neg ? -s64_t'(quo[63:0]) : s64_t'(quo[63:0]);
  endfunction

  function automatic s64_t scale(s64_t x, logic [63:0] rate);
    return mul_div(x, s64_t'(rate), Q_ONE);
  endfunction

  // SEIRD derivatives at point x; total is fixed for the whole step.
  function automatic void seird_rates(input comp5_t x, input logic [63:0] total,
                                      output comp5_t dx);
    s64_t force_t, infect, loss, incub, erec, irec, die;
    force_t = clamp60(scale(x[2], rate_q[seird_pkg::REG_AI])
                      + scale(x[1], rate_q[seird_pkg::REG_AE]));
    infect = (total == 0) ? 0 : mul_div(x[0], force_t, total);
    loss = scale(x[3], rate_q[seird_pkg::REG_GAMMA]);
    incub = scale(x[1], rate_q[seird_pkg::REG_KAPPA]);
    erec = scale(x[1], rate_q[seird_pkg::REG_RHO]);
    irec = scale(x[2], rate_q[seird_pkg::REG_BETA]);
    die = scale(x[2], rate_q[seird_pkg::REG_MU]);
    dx[0] = clamp60(loss - infect);
    dx[1] = clamp60(infect - scale(x[1], 64'(rate_q[seird_pkg::REG_KAPPA])
                                         + 64'(rate_q[seird_pkg::REG_RHO])));
    dx[2] = clamp60(incub - irec - die);
    dx[3] = clamp60(irec + erec - loss);
    dx[4] = die;
  endfunction

  // Advance the predicted compartments by one Heun step.
  function automatic void heun_advance();
    comp5_t x0, x1, d0, d1;
    logic [63:0] total, h;
    s64_t nv;
    total = 0;
    h = 64'(rate_q[seird_pkg::REG_H]);
    for (int k = 0; k < 5; k++) begin
      x0[k] = s64_t'({16'd0, pop_q[k]});
      total += {16'd0, pop_q[k]};
    end
    seird_rates(x0, total, d0);
    for (int k = 0; k < 5; k++) x1[k] = clamp60(x0[k] + scale(d0[k], h));
    seird_rates(x1, total, d1);
    for (int k = 0; k < 5; k++) begin
      nv = x0[k] + mul_div(clamp60(d0[k] + d1[k]), s64_t'(h), Q_ONE << 1);
      if (nv < 0) nv = 0;
      if (nv > s64_t'({16'd0, VAL_MAX})) nv = s64_t'({16'd0, VAL_MAX});
      pop_q[k] = nv[47:0];
    end
  endfunction

  // Apply one accepted request to the predictor and queue its expected result.
  function automatic void predict_request(logic kind, logic [239:0] data);
    seird_result_t r;
    if (kind == seird_pkg::REQ_LOAD) begin
      for (int k = 0; k < 5; k++) pop_q[k] = data[48*k +: 48];
      step_cnt_q = 0;
    end else begin
      heun_advance();
      step_cnt_q = step_cnt_q + 1;
    end
    r = '{steps: step_cnt_q, sus: pop_q[0], exp_c: pop_q[1], inf: pop_q[2],
          rec: pop_q[3], dead: pop_q[4]};
    pending_results.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  // Check every accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    seird_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        err_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("step_index", 48'(want.steps), 48'(m_axis_tdata[31:0]));
        check_field("susceptible_out", want.sus, m_axis_tdata[79:32]);
        check_field("exposed_out", want.exp_c, m_axis_tdata[127:80]);
        check_field("infected_out", want.inf, m_axis_tdata[175:128]);
        check_field("recovered_out", want.rec, m_axis_tdata[223:176]);
        check_field("dead_out", want.dead, m_axis_tdata[271:224]);
      end
    end
  end

  // Receiver: random short and long stalls, plus the long hold when requested.
  always @(posedge clk_i) begin
    int stall_left;
    if (hold_request > 0) begin
      stall_left = hold_request;
      hold_request = 0;
    end
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 90)
                                                : $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Offer one request and hold it until accepted; called just after the clock rises.
  task automatic send_request(logic kind, logic [239:0] data);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_request(kind, data);
    gap = 0;
    if (!no_idle) begin
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(20, 80);
      else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 4);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_load(logic [47:0] s, logic [47:0] e, logic [47:0] i,
                           logic [47:0] r, logic [47:0] d);
    send_request(seird_pkg::REQ_LOAD, {d, r, i, e, s});
  endtask

  task automatic send_step();
    send_request(seird_pkg::REQ_STEP, 240'({$urandom, $urandom, $urandom, $urandom,
                                            $urandom, $urandom, $urandom, $urandom}));
  endtask

  // Drop valid and wait until every expected result is back and the block is idle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  // One register write, with write enable low again before returning so back-to-back writes stay clean.
  task automatic write_rate(logic [seird_pkg::IDX_W-1:0] idx,
                            logic [seird_pkg::RATE_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rate_q[idx] = value;
    @(posedge clk_i);
  endtask

  function automatic logic [47:0] rand_pop();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return 48'd0;
      1: return VAL_MAX;
      2, 3: return r[47:0];
      default: return 48'(r[43:0]);
    endcase
  endfunction

  function automatic logic [seird_pkg::RATE_W-1:0] rand_rate();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return RATE_ONE;
      2: return seird_pkg::RATE_W'($urandom_range(0, 32'h01FF_FFFF)) & RATE_ONE
                ? RATE_ONE : '1 >> 1;
      default: return seird_pkg::RATE_W'($urandom_range(0, 16777216));
    endcase
  endfunction

  task automatic test_default_rates();
    send_load(48'd1000 << 24, 48'd10 << 24, 48'd5 << 24, 48'd0, 48'd0);
    repeat (4) send_step();
    drain();
  endtask

  // All-zero, all-max and mixed zero/max loads; a step with zero total leaves infection at zero.
  task automatic test_load_extremes();
    send_load('0, '0, '0, '0, '0);
    send_step();
    send_step();
    send_load(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);
    send_step();
    send_load(VAL_MAX, '0, VAL_MAX, '0, VAL_MAX);
    send_step();
    send_load('0, VAL_MAX, '0, VAL_MAX, '0);
    send_step();
    drain();
  endtask

  // Rates of one with a full step drive the predictor point past 0..max; then all-zero rates.
  task automatic test_large_rates();
    for (int k = 0; k < seird_pkg::NREG; k++) write_rate(seird_pkg::IDX_W'(k), RATE_ONE);
    send_load(VAL_MAX, VAL_MAX >> 1, VAL_MAX >> 2, 48'd1 << 40, 48'd3);
    repeat (3) send_step();
    drain();
    for (int k = 0; k < seird_pkg::NREG; k++) write_rate(seird_pkg::IDX_W'(k), '0);
    send_load(48'd7 << 30, 48'd1 << 30, 48'd1 << 30, 48'd1 << 30, 48'd0);
    send_step();
    drain();
    for (int k = 0; k < seird_pkg::NREG; k++) begin
      write_rate(seird_pkg::IDX_W'(k), seird_pkg::REG_RESET[k]);
    end
  endtask

  // Long receiver hold while the sender keeps offering steps back to back.
  task automatic test_backpressure();
    send_load(48'd5000 << 24, 48'd50 << 24, 48'd20 << 24, 48'd1 << 24, 48'd0);
    no_idle = 1'b1;
    hold_request = 1500;
    repeat (6) send_step();
    drain();
    no_idle = 1'b0;
  endtask

  // Random runs: a load (sometimes a step instead) followed by a burst of steps, rates changed between phases.
  task automatic test_random_runs(int target);
    int sent;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 6) == 0) begin
        drain();
        for (int k = 0; k < seird_pkg::NREG; k++) begin
          if ($urandom_range(0, 1)) write_rate(seird_pkg::IDX_W'(k), rand_rate());
        end
        if ($urandom_range(0, 3) != 0) begin
          write_rate(seird_pkg::REG_H, seird_pkg::RATE_W'($urandom_range(0, 2000000)));
        end
      end
      no_idle = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0) begin
        send_step();   // step without a fresh load keeps the previous point
      end else begin
        send_load(rand_pop(), rand_pop(), rand_pop(), rand_pop(), rand_pop());
      end
      sent++;
      repeat ($urandom_range(1, 12)) begin
        send_step();
        sent++;
      end
    end
    no_idle = 1'b0;
    drain();
  endtask

  initial begin
    for (int k = 0; k < seird_pkg::NREG; k++) rate_q[k] = seird_pkg::REG_RESET[k];
    for (int k = 0; k < 5; k++) pop_q[k] = '0;
    step_cnt_q = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_step();   // step from reset state: zero total
    drain();
    test_default_rates();
    test_load_extremes();
    test_large_rates();
    test_backpressure();
    test_random_runs(630);
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_seird_heun_step passed");
    end else begin
      $display("tb_seird_heun_step failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_seird_heun_step failed");
    $finish;
  end

endmodule
